// ----- rtl/atw_pkg.sv -----
// ----------------------------------------------------------------------------
// atw_pkg
// Shared types, constants and helper functions of the ANSI text terminal
// writer.
// ----------------------------------------------------------------------------
package atw_pkg;

   localparam int NUM_TERMINALS  = 4;
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int TERM_BITS      = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;
   localparam int CELL_BITS      = $clog2(SCREEN_CELLS);
   localparam int MEM_DEPTH      = NUM_TERMINALS * SCREEN_CELLS;
   localparam int MEM_ADDR_BITS  = $clog2(MEM_DEPTH);

   localparam logic [7:0]  CHAR_ESC     = 8'h1B;
   localparam logic [7:0]  CHAR_LBRACK  = 8'h5B;
   localparam logic [7:0]  CHAR_SGR     = 8'h6D;
   localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [7:0]  DEFAULT_COLOUR = 8'h07;
   localparam logic [9:0]  SGR_MAX      = 10'd1023;
   localparam logic [15:0] CLEAR_CELL   = 16'h0700;

   localparam logic COMMAND_PUT  = 1'b0;
   localparam logic COMMAND_READ = 1'b1;

   typedef enum logic [1:0] {
      PHASE_NORMAL = 2'd0,
      PHASE_ESC    = 2'd1,
      PHASE_CSI    = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_WRITE,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       command;
      logic [2:0] terminal;
      logic [7:0] char_code;
      logic [6:0] cell_col;
      logic [4:0] cell_row;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [15:0] cell_value;
      logic        cell_written;
      logic        scrolled;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
   } rsp_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic latch_req;     // capture the request and the terminal's state
      logic clear_step;    // write one clear cell, advance the sweep counter
      logic do_read;       // issue memory read of the requested cell
      logic do_write;      // write the new character cell
      logic escape_only;   // commit escape machine and newline state
      logic scroll_start;  // reset the scroll pointer
      logic scroll_rd;     // read the cell one row below the pointer
      logic scroll_wr;     // write it at the pointer, advance
      logic blank_wr;      // write a blank cell in the last row, advance
      logic finish;        // commit cursor, present the result
      logic reject;        // present a bad-terminal result
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic bad_terminal;
      logic is_read;
      logic is_print;      // put in normal phase that is not ESC: a printed byte or a newline
      logic needs_scroll;
      logic is_newline;
      logic scroll_last;   // pointer at last moved cell
      logic blank_last;    // pointer at last blank cell
   } sts_type;

   // Map an SGR colour code to its 3-bit VGA colour.
   function automatic logic [2:0] ansi_palette(input logic [2:0] code);
      case (code)
         3'd0: ansi_palette = 3'd0;
         3'd1: ansi_palette = 3'd4;
         3'd2: ansi_palette = 3'd2;
         3'd3: ansi_palette = 3'd6;
         3'd4: ansi_palette = 3'd1;
         3'd5: ansi_palette = 3'd5;
         3'd6: ansi_palette = 3'd3;
         default: ansi_palette = 3'd7;
      endcase
   endfunction

   // Apply one SGR parameter to a colour byte.
   function automatic logic [7:0] apply_sgr(input logic [9:0] p, input logic [7:0] c);
      logic [9:0] d;
      logic [7:0] r;
      r = c;
      d = 10'd0;
      if (p == 10'd0) begin
         r = DEFAULT_COLOUR;
      end else if (p >= 10'd30 && p <= 10'd37) begin
         d = p - 10'd30;
         r = {c[7:4], 1'b0, ansi_palette(d[2:0])};
      end else if (p >= 10'd90 && p <= 10'd97) begin
         d = p - 10'd90;
         r = {c[7:4], 1'b1, ansi_palette(d[2:0])};
      end else if (p >= 10'd40 && p <= 10'd47) begin
         d = p - 10'd40;
         r = {1'b0, ansi_palette(d[2:0]), c[3:0]};
      end else if (p >= 10'd100 && p <= 10'd107) begin
         d = p - 10'd100;
         r = {1'b1, ansi_palette(d[2:0]), c[3:0]};
      end
      return r;
   endfunction

endpackage

// ----- rtl/atw_ram.sv -----
// ----------------------------------------------------------------------------
// atw_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module atw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One access per cycle: a write when enabled, and always a registered read of the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

// ----- rtl/atw_datapath.sv -----
// ----------------------------------------------------------------------------
// atw_datapath
// Per-terminal state, escape machine, cursor arithmetic and cell store
// addressing for the ANSI text terminal writer.
// ----------------------------------------------------------------------------
module atw_datapath (
   input  logic            clock,
   input  logic            reset,
   input  atw_pkg::req_type req_word,
   input  atw_pkg::cmd_type cmd,
   output atw_pkg::sts_type sts,
   output logic            rsp_valid,
   output atw_pkg::rsp_type rsp_word
);
   import atw_pkg::*;

   // Per-terminal registers.
   logic [6:0]  col_ff    [NUM_TERMINALS];
   logic [4:0]  row_ff    [NUM_TERMINALS];
   logic [7:0]  colour_ff [NUM_TERMINALS];
   phase_type   phase_ff  [NUM_TERMINALS];
   logic [9:0]  sgr_ff    [NUM_TERMINALS];

   // Captured request and working copy of its terminal.
   req_type     req_ff;
   logic [TERM_BITS-1:0] term_ff;
   logic        bad_ff;
   logic [6:0]  wcol_ff;
   logic [4:0]  wrow_ff;
   logic [7:0]  wcolour_ff;
   phase_type   wphase_ff;
   logic        scrolled_ff;

   // Sweep and scroll pointers.
   logic [MEM_ADDR_BITS:0] clr_ff;
   logic [CELL_BITS-1:0]   ptr_ff;
   logic                   rd_pending_ff;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Memory port.
   logic                     mem_we;
   logic [MEM_ADDR_BITS-1:0] mem_addr;
   logic [15:0]              mem_wdata;
   logic [15:0]              mem_rdata;

   logic [TERM_BITS-1:0] req_term;
   logic [6:0]  cur_col;
   logic [4:0]  cur_row;
   logic [MEM_ADDR_BITS-1:0] term_base;
   logic [CELL_BITS-1:0]     write_idx;
   logic [CELL_BITS-1:0]     read_idx;
   logic [13:0] sgr_mul;

   assign req_term = req_word.terminal[TERM_BITS-1:0];

   // Cursor before the print: newline or pending wrap moves to the next line.
   always_comb begin
      cur_col = wcol_ff;
      cur_row = wrow_ff;
      if (req_ff.char_code == CHAR_NEWLINE || wcol_ff >= 7'(SCREEN_COLUMNS)) begin
         cur_col = 7'd0;
         cur_row = wrow_ff + 5'd1;
      end
   end

   assign term_base = MEM_ADDR_BITS'(term_ff) * MEM_ADDR_BITS'(SCREEN_CELLS);
   assign write_idx = CELL_BITS'(wrow_ff) * CELL_BITS'(SCREEN_COLUMNS)
                      + CELL_BITS'(wcol_ff);
   assign read_idx  = CELL_BITS'(req_ff.cell_row) * CELL_BITS'(SCREEN_COLUMNS)
                      + CELL_BITS'(req_ff.cell_col);

   // Status to the controller. The print decision uses the phase seen when
   // the word was captured, so it holds after the escape machine moves on.
   always_comb begin
      sts.clear_done   = (clr_ff == (MEM_ADDR_BITS+1)'(MEM_DEPTH));
      sts.bad_terminal = bad_ff;
      sts.is_read      = (req_ff.command == COMMAND_READ);
      sts.is_print     = (req_ff.command == COMMAND_PUT)
                         && (wphase_ff == PHASE_NORMAL)
                         && (req_ff.char_code != CHAR_ESC);
      sts.needs_scroll = (cur_row >= 5'(SCREEN_ROWS));
      sts.is_newline   = (req_ff.char_code == CHAR_NEWLINE);
      sts.scroll_last  = (ptr_ff == CELL_BITS'(SCREEN_CELLS - SCREEN_COLUMNS - 1));
      sts.blank_last   = (ptr_ff == CELL_BITS'(SCREEN_CELLS - 1));
   end

   // Memory address and data selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = term_base + MEM_ADDR_BITS'(read_idx);
      mem_wdata = {req_ff.char_code == CHAR_NEWLINE ? 8'd0 : wcolour_ff, req_ff.char_code};
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_addr  = clr_ff[MEM_ADDR_BITS-1:0];
         mem_wdata = CLEAR_CELL;
      end else if (cmd.do_write) begin
         mem_we    = 1'b1;
         mem_addr  = term_base + MEM_ADDR_BITS'(write_idx);
         mem_wdata = {wcolour_ff, req_ff.char_code};
      end else if (cmd.scroll_rd) begin
         mem_addr  = term_base + MEM_ADDR_BITS'(ptr_ff)
                     + MEM_ADDR_BITS'(SCREEN_COLUMNS);
      end else if (cmd.scroll_wr) begin
         mem_we    = 1'b1;
         mem_addr  = term_base + MEM_ADDR_BITS'(ptr_ff);
         mem_wdata = mem_rdata;
      end else if (cmd.blank_wr) begin
         mem_we    = 1'b1;
         mem_addr  = term_base + MEM_ADDR_BITS'(ptr_ff);
         mem_wdata = {wcolour_ff, 8'd0};
      end
   end

   atw_ram #(
      .WIDTH (16),
      .DEPTH (MEM_DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   assign sgr_mul = 14'(sgr_ff[term_ff]) * 14'd10
                    + 14'(req_ff.char_code - CHAR_ZERO);

   // Control registers: sweep counter and output strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.finish || cmd.reject;
      end
   end

   // Per-terminal state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TERMINALS; t++) begin
            col_ff[t]    <= '0;
            row_ff[t]    <= '0;
            colour_ff[t] <= DEFAULT_COLOUR;
            phase_ff[t]  <= PHASE_NORMAL;
            sgr_ff[t]    <= '0;
         end
      end else begin
         if (cmd.escape_only && req_ff.command == COMMAND_PUT) begin
            case (phase_ff[term_ff])
               PHASE_ESC: begin
                  if (req_ff.char_code == CHAR_LBRACK) begin
                     phase_ff[term_ff] <= PHASE_CSI;
                     sgr_ff[term_ff]   <= '0;
                  end else begin
                     phase_ff[term_ff] <= PHASE_NORMAL;
                  end
               end
               PHASE_CSI: begin
                  if (req_ff.char_code >= CHAR_ZERO && req_ff.char_code <= CHAR_NINE) begin
                     sgr_ff[term_ff] <= (sgr_mul > 14'(SGR_MAX)) ? SGR_MAX : sgr_mul[9:0];
                  end else if (req_ff.char_code == CHAR_SGR) begin
                     colour_ff[term_ff] <= apply_sgr(sgr_ff[term_ff], colour_ff[term_ff]);
                     phase_ff[term_ff]  <= PHASE_NORMAL;
                  end
               end
               default: begin
                  if (req_ff.char_code == CHAR_ESC) begin
                     phase_ff[term_ff] <= PHASE_ESC;
                  end
               end
            endcase
         end
         if (cmd.finish && sts.is_print) begin
            col_ff[term_ff] <= wcol_ff;
            row_ff[term_ff] <= wrow_ff;
         end
      end
   end

   // Request capture, working cursor and scroll pointer.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff      <= req_word;
         term_ff     <= req_term;
         bad_ff      <= (32'(req_word.terminal) >= NUM_TERMINALS);
         scrolled_ff <= 1'b0;
         rd_pending_ff <= 1'b0;
         if (32'(req_word.terminal) < NUM_TERMINALS) begin
            wcol_ff    <= col_ff[req_term];
            wrow_ff    <= row_ff[req_term];
            wcolour_ff <= colour_ff[req_term];
            wphase_ff  <= phase_ff[req_term];
         end
      end
      if (cmd.do_read) begin
         rd_pending_ff <= 1'b1;
      end
      // The decide step fixes up the cursor for newline, wrap and scroll.
      if (cmd.escape_only && sts.is_print) begin
         wcol_ff <= cur_col;
         wrow_ff <= sts.needs_scroll ? 5'(SCREEN_ROWS - 1) : cur_row;
      end
      if (cmd.scroll_start) begin
         ptr_ff      <= '0;
         scrolled_ff <= 1'b1;
      end
      if (cmd.scroll_wr || cmd.blank_wr) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
      if (cmd.do_write) begin
         wcol_ff <= wcol_ff + 7'd1;
      end
   end

   // Next result word.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.reject) begin
         rsp_in        = '0;
         rsp_in.status = 1'b1;
      end else if (cmd.finish) begin
         rsp_in              = '0;
         rsp_in.cursor_col   = col_ff[term_ff];
         rsp_in.cursor_row   = row_ff[term_ff];
         if (sts.is_read) begin
            if (rd_pending_ff && req_ff.cell_col < 7'(SCREEN_COLUMNS)
                && req_ff.cell_row < 5'(SCREEN_ROWS)) begin
               rsp_in.cell_value = mem_rdata;
            end
         end else if (sts.is_print) begin
            rsp_in.scrolled   = scrolled_ff;
            rsp_in.cursor_col = wcol_ff;
            rsp_in.cursor_row = wrow_ff;
            if (req_ff.char_code != CHAR_NEWLINE) begin
               rsp_in.cell_value   = {wcolour_ff, req_ff.char_code};
               rsp_in.cell_written = 1'b1;
            end
         end
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- rtl/atw_control.sv -----
// ----------------------------------------------------------------------------
// atw_control
// Sequencer of the ANSI text terminal writer: clear sweep, reads, cell
// writes and the scroll walk.
// ----------------------------------------------------------------------------
module atw_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  atw_pkg::sts_type sts,
   output atw_pkg::cmd_type cmd
);
   import atw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.clear_step = 1'b1;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.bad_terminal) begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end else if (sts.is_read) begin
               cmd.do_read = 1'b1;
               state_in    = ST_READ;
            end else begin
               cmd.escape_only = 1'b1;
               if (sts.is_print && sts.needs_scroll) begin
                  cmd.scroll_start = 1'b1;
                  state_in         = ST_SCROLL_RD;
               end else if (sts.is_print && !sts.is_newline) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_SCROLL_RD: begin
            cmd.scroll_rd = 1'b1;
            state_in      = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            cmd.scroll_wr = 1'b1;
            state_in      = sts.scroll_last ? ST_BLANK : ST_SCROLL_RD;
         end
         ST_BLANK: begin
            cmd.blank_wr = 1'b1;
            if (sts.blank_last) begin
               state_in = sts.is_newline ? ST_FINISH : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.do_write = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/ansi_text_terminal_writer.sv -----
// After a word is accepted, a bad terminal is rejected from the decide state;
// an escape byte or a newline goes on to finish, a read passes the read state
// and a printed cell the write state. A scroll walk, set by the single cell store
// port, moves each cell up one row by a read and a write, then blanks the last row.
// A new word is taken only in idle, when busy is low. After reset, a clearing
// pass writes every cell of all terminals, one per cycle; busy is high meanwhile.
// ----------------------------------------------------------------------------
// ansi_text_terminal_writer
// Top level: multi-terminal ANSI text writer with a shared cell store.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module ansi_text_terminal_writer (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  atw_pkg::req_type req_word,
   output logic             rsp_valid,
   output atw_pkg::rsp_type rsp_word
);
   import atw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   atw_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   atw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
